@@ sv/cbct_pkg.sv @@
package cbct_pkg;
  localparam int unsigned CoordFracBits  = 16;
  localparam int unsigned NormalFracBits = 14;
  localparam int unsigned PosW  = 32;
  localparam int unsigned SizeW = 30;
  localparam int unsigned NormW = 16;
  localparam int unsigned PenW  = 31;
  localparam int unsigned OffW  = 34;  // signed offsets after clamping
  localparam int unsigned MagW  = 33;  // magnitudes of offsets
  localparam int unsigned SqW   = 66;  // squared distance
  localparam int unsigned DistW = 33;  // floor sqrt of SqW bits

  typedef enum logic [1:0] {
    PairCircCirc = 2'b00,
    PairCircBox  = 2'b01,
    PairBoxCirc  = 2'b10,
    PairBoxBox   = 2'b11
  } pair_e;

  // Stage-one result: one contact problem reduced to offset and radius.
  typedef struct packed {
    logic                     round;   // circle-type test
    logic                     flip;    // reverse normal
    logic signed [OffW-1:0]   dx;
    logic signed [OffW-1:0]   dy;
    logic        [MagW-1:0]   adx;
    logic        [MagW-1:0]   ady;
    logic        [MagW-1:0]   r;
    logic                     bb_hit;
    logic                     bb_use_x;
    logic                     bb_neg;
    logic        [PenW-1:0]   bb_pen;
  } setup_t;
endpackage

@@ sv/cbct_setup.sv @@
module cbct_setup
  import cbct_pkg::*;
(
  input  logic                     a_is_box_i,
  input  logic signed [PosW-1:0]   a_x_i,
  input  logic signed [PosW-1:0]   a_y_i,
  input  logic        [SizeW-1:0]  a_size_i,
  input  logic        [SizeW-1:0]  a_half_height_i,
  input  logic                     b_is_box_i,
  input  logic signed [PosW-1:0]   b_x_i,
  input  logic signed [PosW-1:0]   b_y_i,
  input  logic        [SizeW-1:0]  b_size_i,
  input  logic        [SizeW-1:0]  b_half_height_i,
  output setup_t                   setup_o
);
  logic signed [OffW-1:0] ddx, ddy, hx, hy, rx, ry, cx, cy, ox, oy;
  logic        [MagW-1:0] adx, ady;
  pair_e                  pair;

  always_comb begin
    pair = pair_e'({a_is_box_i, b_is_box_i});
    ddx = OffW'(b_x_i) - OffW'(a_x_i);
    ddy = OffW'(b_y_i) - OffW'(a_y_i);
    hx  = '0;
    hy  = '0;
    setup_o = '0;
    unique case (pair)
      PairCircCirc: setup_o.r = MagW'(a_size_i) + MagW'(b_size_i);
      PairCircBox: begin
        hx = OffW'(b_size_i);
        hy = OffW'(b_half_height_i);
        setup_o.r = MagW'(a_size_i);
        setup_o.flip = 1'b1;
      end
      PairBoxCirc: begin
        hx = OffW'(a_size_i);
        hy = OffW'(a_half_height_i);
        setup_o.r = MagW'(b_size_i);
      end
      default: setup_o.r = '0;
    endcase
    // Clamp point offset into the box; circle-box uses A relative to B.
    rx = setup_o.flip ? -ddx : ddx;
    ry = setup_o.flip ? -ddy : ddy;
    cx = (rx > hx) ? hx : ((rx < -hx) ? -hx : rx);
    cy = (ry > hy) ? hy : ((ry < -hy) ? -hy : ry);
    setup_o.dx = rx - cx;
    setup_o.dy = ry - cy;
    adx = setup_o.dx[OffW-1] ? MagW'(-setup_o.dx) : MagW'(setup_o.dx);
    ady = setup_o.dy[OffW-1] ? MagW'(-setup_o.dy) : MagW'(setup_o.dy);
    setup_o.adx = adx;
    setup_o.ady = ady;
    setup_o.round = (pair != PairBoxBox);
    // Box-box overlap on each axis.
    ox = OffW'(a_size_i) + OffW'(b_size_i)
       - (ddx[OffW-1] ? -ddx : ddx);
    oy = OffW'(a_half_height_i) + OffW'(b_half_height_i)
       - (ddy[OffW-1] ? -ddy : ddy);
    setup_o.bb_hit   = (pair == PairBoxBox) && (ox > 0) && (oy > 0);
    setup_o.bb_use_x = (ox < oy);
    setup_o.bb_neg   = setup_o.bb_use_x ? !(ddx > 0) : !(ddy > 0);
    setup_o.bb_pen   = setup_o.bb_use_x ? PenW'(ox) : PenW'(oy);
  end
endmodule

@@ sv/cbct_sqrt.sv @@
// Pipelined restoring square root, one result bit per stage.
module cbct_sqrt
  import cbct_pkg::*;
#(
  parameter type side_t = logic
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [SqW-1:0]    rad_i,
  input  side_t             side_i,
  output logic              valid_o,
  output logic [DistW-1:0]  root_o,
  output side_t             side_o
);
  localparam int unsigned N = DistW;
  logic [N:0]       vld_q;
  logic [SqW-1:0]   rem_q  [N+1];
  logic [DistW-1:0] res_q  [N+1];
  logic [SqW-1:0]   rest_q [N+1];
  side_t            side_q [N+1];

  always_comb begin
    vld_q[0]  = valid_i;
    rem_q[0]  = '0;
    res_q[0]  = '0;
    rest_q[0] = rad_i;
    side_q[0] = side_i;
  end

  for (genvar i = 0; i < N; i++) begin : g_st
    logic [SqW-1:0]   rem_d, trial;
    logic [DistW-1:0] res_d;
    always_comb begin
      rem_d = {rem_q[i][SqW-3:0], rest_q[i][SqW-1 -: 2]};
      trial = SqW'({res_q[i], 2'b01});
      if (rem_d >= trial) begin
        rem_d = rem_d - trial;
        res_d = {res_q[i][DistW-2:0], 1'b1};
      end else begin
        res_d = {res_q[i][DistW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[i+1] <= vld_q[i];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i+1]  <= rem_d;
        res_q[i+1]  <= res_d;
        rest_q[i+1] <= {rest_q[i][SqW-3:0], 2'b00};
        side_q[i+1] <= side_q[i];
      end
    end
  end

  assign valid_o = vld_q[N];
  assign root_o  = res_q[N];
  assign side_o  = side_q[N];
endmodule

@@ sv/cbct_div.sv @@
// Pipelined unsigned restoring divider, one quotient bit per stage.
module cbct_div
  import cbct_pkg::*;
#(
  parameter int unsigned NumW = 48,
  parameter int unsigned DenW = 34,
  parameter type side_t = logic
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [NumW-1:0]  num_i,
  input  logic [DenW-1:0]  den_i,
  input  side_t            side_i,
  output logic             valid_o,
  output logic [NumW-1:0]  quo_o,
  output side_t            side_o
);
  localparam int unsigned RemW = DenW + 1;
  logic [NumW:0]     vld_q;
  logic [RemW-1:0]   rem_q [NumW+1];
  logic [NumW-1:0]   num_q [NumW+1];
  logic [DenW-1:0]   den_q [NumW+1];
  side_t             side_q [NumW+1];

  always_comb begin
    vld_q[0]  = valid_i;
    rem_q[0]  = '0;
    num_q[0]  = num_i;
    den_q[0]  = den_i;
    side_q[0] = side_i;
  end

  for (genvar i = 0; i < NumW; i++) begin : g_st
    logic [RemW-1:0] sh, rem_d;
    logic [NumW-1:0] num_d;
    always_comb begin
      sh    = {rem_q[i][RemW-2:0], num_q[i][NumW-1]};
      num_d = {num_q[i][NumW-2:0], 1'b0};
      rem_d = sh;
      if (sh >= RemW'(den_q[i])) begin
        rem_d    = sh - RemW'(den_q[i]);
        num_d[0] = 1'b1;
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[i+1] <= vld_q[i];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i+1]  <= rem_d;
        num_q[i+1]  <= num_d;
        den_q[i+1]  <= den_q[i];
        side_q[i+1] <= side_q[i];
      end
    end
  end

  assign valid_o = vld_q[NumW];
  assign quo_o   = num_q[NumW];
  assign side_o  = side_q[NumW];
endmodule

@@ sv/circle_box_contact_test.sv @@
// Stages from an accepted input beat to its result beat: setup, two square
//   stages, one 33-stage square root, one 49-stage divider per normal
//   component, output register.
// Throughput: one pair per cycle; every stage is a pipeline stage and the
//   whole pipe advances together whenever the output register can move.
// Reset: rst_ni clears all valid bits asynchronously; payload is not reset.
module circle_box_contact_test
  import cbct_pkg::*;
#(
  parameter int unsigned NORMAL_FRAC_BITS = NormalFracBits
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    a_is_box_i,
  input  logic signed [PosW-1:0]  a_x_i,
  input  logic signed [PosW-1:0]  a_y_i,
  input  logic        [SizeW-1:0] a_size_i,
  input  logic        [SizeW-1:0] a_half_height_i,
  input  logic                    b_is_box_i,
  input  logic signed [PosW-1:0]  b_x_i,
  input  logic signed [PosW-1:0]  b_y_i,
  input  logic        [SizeW-1:0] b_size_i,
  input  logic        [SizeW-1:0] b_half_height_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    hit_o,
  output logic signed [NormW-1:0] normal_x_o,
  output logic signed [NormW-1:0] normal_y_o,
  output logic        [PenW-1:0]  penetration_o
);
  // Numerator of a normal component: |c| * 2^(NFB+1) + distance fits here.
  localparam int unsigned NumW = MagW + NORMAL_FRAC_BITS + 2;
  localparam int unsigned DenW = DistW + 1;

  // Information that travels beside the square root and the dividers.
  typedef struct packed {
    logic              hit;
    logic              round;
    logic              flip;
    logic              sx;
    logic              sy;
    logic [MagW-1:0]   adx;
    logic [MagW-1:0]   ady;
    logic [MagW-1:0]   r;
    logic              bb_use_x;
    logic              bb_neg;
    logic [PenW-1:0]   bb_pen;
  } side_t;

  typedef struct packed {
    logic              hit;
    logic              round;
    logic              flip;
    logic              sx;
    logic              sy;
    logic              zero;
    logic              bb_use_x;
    logic              bb_neg;
    logic [PenW-1:0]   pen;
  } tail_t;

  // The whole pipe moves when the output register is empty or being taken.
  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // Stage 1: reduce the pair to an offset and a radius.
  setup_t setup, s1_q;
  logic   v1_q;
  cbct_setup u_setup (
    .a_is_box_i, .a_x_i, .a_y_i, .a_size_i, .a_half_height_i,
    .b_is_box_i, .b_x_i, .b_y_i, .b_size_i, .b_half_height_i,
    .setup_o (setup)
  );

  // Stage 2: squares (one multiplier each). Stage 3: sum and compare.
  logic [SqW-1:0] sqx_q, sqy_q, r2_q;
  setup_t         s2_q;
  logic           v2_q, v3_q;
  side_t          side3_q;
  logic [SqW-1:0] d2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q  <= setup;
      sqx_q <= SqW'(s1_q.adx) * SqW'(s1_q.adx);
      sqy_q <= SqW'(s1_q.ady) * SqW'(s1_q.ady);
      r2_q  <= SqW'(s1_q.r) * SqW'(s1_q.r);
      s2_q  <= s1_q;
      d2_q  <= sqx_q + sqy_q;
      side3_q.round    <= s2_q.round;
      side3_q.flip     <= s2_q.flip;
      side3_q.sx       <= s2_q.dx[OffW-1];
      side3_q.sy       <= s2_q.dy[OffW-1];
      side3_q.adx      <= s2_q.adx;
      side3_q.ady      <= s2_q.ady;
      side3_q.r        <= s2_q.r;
      side3_q.bb_use_x <= s2_q.bb_use_x;
      side3_q.bb_neg   <= s2_q.bb_neg;
      side3_q.bb_pen   <= s2_q.bb_pen;
      // Strict compares: touching is no hit. Squares are summed exactly.
      side3_q.hit      <= s2_q.round
                          ? (s2_q.adx < s2_q.r) && (s2_q.ady < s2_q.r)
                            && ((sqx_q + sqy_q) < r2_q)
                          : s2_q.bb_hit;
    end
  end

  // Square root of the squared distance.
  logic              v4;
  logic [DistW-1:0]  root;
  side_t             side4;
  cbct_sqrt #(.side_t(side_t)) u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v3_q), .rad_i(d2_q),
    .side_i(side3_q), .valid_o(v4), .root_o(root), .side_o(side4)
  );

  // Rounded division |c| * 2^NFB / root as (|c|*2^(NFB+1) + root) / (2*root).
  logic [NumW-1:0] numx, numy, qx, qy;
  logic [DenW-1:0] den;
  tail_t           tail4, tail5, tail5y;
  logic            v5, v5y;
  always_comb begin
    den  = {root, 1'b0};
    numx = (NumW'(side4.adx) << (NORMAL_FRAC_BITS + 1)) + NumW'(root);
    numy = (NumW'(side4.ady) << (NORMAL_FRAC_BITS + 1)) + NumW'(root);
    tail4.hit      = side4.hit;
    tail4.round    = side4.round;
    tail4.flip     = side4.flip;
    tail4.sx       = side4.sx;
    tail4.sy       = side4.sy;
    tail4.zero     = (root == '0);
    tail4.bb_use_x = side4.bb_use_x;
    tail4.bb_neg   = side4.bb_neg;
    tail4.pen      = side4.round ? PenW'(side4.r - MagW'(root)) : side4.bb_pen;
  end

  cbct_div #(.NumW(NumW), .DenW(DenW), .side_t(tail_t)) u_div_x (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v4), .num_i(numx),
    .den_i(den), .side_i(tail4), .valid_o(v5), .quo_o(qx), .side_o(tail5)
  );
  cbct_div #(.NumW(NumW), .DenW(DenW), .side_t(tail_t)) u_div_y (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v4), .num_i(numy),
    .den_i(den), .side_i(tail4), .valid_o(v5y), .quo_o(qy), .side_o(tail5y)
  );

  // Final selection of the normal and the output register.
  logic signed [NormW-1:0] one, mx, my, nx_d, ny_d;
  logic                    negx, negy;
  always_comb begin
    one  = NormW'(1) << NORMAL_FRAC_BITS;
    mx   = NormW'(qx);
    my   = NormW'(qy);
    negx = tail5.sx ^ tail5.flip;
    negy = tail5.sy ^ tail5.flip;
    nx_d = '0;
    ny_d = '0;
    if (!tail5.hit) begin
      nx_d = '0;
    end else if (tail5.round) begin
      if (tail5.zero) begin
        nx_d = one;
      end else begin
        nx_d = negx ? -mx : mx;
        ny_d = negy ? -my : my;
      end
    end else if (tail5.bb_use_x) begin
      nx_d = tail5.bb_neg ? -one : one;
    end else begin
      ny_d = tail5.bb_neg ? -one : one;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= v5;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_o         <= tail5.hit;
      normal_x_o    <= nx_d;
      normal_y_o    <= ny_d;
      penetration_o <= tail5.hit ? tail5.pen : '0;
    end
  end

  // Both dividers run in lockstep and carry the same side information.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v5 == v5y && (!v5 || tail5 == tail5y))
    else $error("divider lanes out of step");
  // A result without a hit carries a zero normal and depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> normal_x_o == '0 && normal_y_o == '0
                              && penetration_o == '0)
    else $error("miss with nonzero payload");
  // A stalled result stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(normal_x_o))
    else $error("stalled result changed");
endmodule

@@ dv/tb_circle_box_contact_test.sv @@
`timescale 1ns / 1ps

module tb_circle_box_contact_test;
  import cbct_pkg::*;

  // One shape pair as presented on the input channel.
  typedef struct packed {
    logic                    a_box;
    logic signed [PosW-1:0]  ax;
    logic signed [PosW-1:0]  ay;
    logic        [SizeW-1:0] as_;
    logic        [SizeW-1:0] ah;
    logic                    b_box;
    logic signed [PosW-1:0]  bx;
    logic signed [PosW-1:0]  by;
    logic        [SizeW-1:0] bs;
    logic        [SizeW-1:0] bh;
  } shape_pair_t;

  // One contact report as seen on the output channel.
  typedef struct packed {
    logic                    hit;
    logic signed [NormW-1:0] nx;
    logic signed [NormW-1:0] ny;
    logic        [PenW-1:0]  pen;
  } contact_t;

  localparam int PipeLatency  = 86;
  localparam int StallLimit   = 5000;
  localparam int RandomPairs  = 1650;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic hit_o;
  logic signed [NormW-1:0] normal_x_o, normal_y_o;
  logic [PenW-1:0] penetration_o;
  shape_pair_t drive_pair = '0;

  shape_pair_t pending_pairs[$];
  contact_t    expected_contacts[$];
  int          errors = 0;
  int          idle_phase = 0;     // 0: sender 35/receiver 87, 1: swapped, 2: none
  bit          hold_off = 1'b0;    // long receiver stall requested by the sequencer
  int          hold_cnt = 0;
  int          quiet_cycles = 0;

  always #6 clk_i = ~clk_i;

  circle_box_contact_test dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .a_is_box_i(drive_pair.a_box), .a_x_i(drive_pair.ax), .a_y_i(drive_pair.ay),
    .a_size_i(drive_pair.as_), .a_half_height_i(drive_pair.ah),
    .b_is_box_i(drive_pair.b_box), .b_x_i(drive_pair.bx), .b_y_i(drive_pair.by),
    .b_size_i(drive_pair.bs), .b_half_height_i(drive_pair.bh),
    .out_valid_o, .out_ready_i, .hit_o, .normal_x_o, .normal_y_o, .penetration_o
  );

  // Integer square root, floor, by the bitwise restoring method.
  function automatic logic [63:0] floor_sqrt(logic [65:0] v);
    logic [65:0] rem, res, bit_w;
    rem = v;
    res = '0;
    bit_w = 66'd1 << 64;
    while (bit_w > rem) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (rem >= res + bit_w) begin
        rem = rem - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res[63:0];
  endfunction

  // Normal component c/root_len in Q1.14, rounded with ties away from zero.
  function automatic longint unit_component(longint c, longint root_len);
    longint mag, q;
    mag = (c < 0) ? -c : c;
    q = ((mag <<< (NormalFracBits + 1)) + root_len) / (root_len <<< 1);
    return (c < 0) ? -q : q;
  endfunction

  // Contact of a point offset (dx,dy) against a disc of radius r.
  function automatic contact_t disc_contact(longint dx, longint dy, longint r, bit flip);
    contact_t res;
    longint adx, ady, root_len;
    logic [65:0] d2;
    res = '0;
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    if (adx >= r || ady >= r) return res;
    d2 = 66'(adx) * 66'(adx) + 66'(ady) * 66'(ady);
    if (d2 >= 66'(r) * 66'(r)) return res;
    root_len = longint'(floor_sqrt(d2));
    res.hit = 1'b1;
    if (root_len == 0) begin
      // Coincident centres, or circle centre inside the box: fixed +X normal.
      res.nx = NormW'(longint'(1) <<< NormalFracBits);
      res.ny = '0;
    end else begin
      res.nx = NormW'(flip ? -unit_component(dx, root_len) : unit_component(dx, root_len));
      res.ny = NormW'(flip ? -unit_component(dy, root_len) : unit_component(dy, root_len));
    end
    res.pen = PenW'(r - root_len);
    return res;
  endfunction

  function automatic longint clamp_half(longint v, longint h);
    if (v > h) return h;
    if (v < -h) return -h;
    return v;
  endfunction

  // Predicts the contact report for one shape pair.
  function automatic contact_t predict_contact(shape_pair_t p);
    contact_t res;
    longint ax, ay, bx, by, as_, ah, bs, bh, rx, ry, ox, oy, one;
    res = '0;
    ax = p.ax; ay = p.ay; bx = p.bx; by = p.by;
    as_ = p.as_; ah = p.ah; bs = p.bs; bh = p.bh;
    one = longint'(1) <<< NormalFracBits;
    case ({p.a_box, p.b_box})
      PairCircCirc: res = disc_contact(bx - ax, by - ay, as_ + bs, 1'b0);
      PairCircBox: begin
        rx = ax - bx;
        ry = ay - by;
        res = disc_contact(rx - clamp_half(rx, bs), ry - clamp_half(ry, bh), as_, 1'b1);
      end
      PairBoxCirc: begin
        rx = bx - ax;
        ry = by - ay;
        res = disc_contact(rx - clamp_half(rx, as_), ry - clamp_half(ry, ah), bs, 1'b0);
      end
      default: begin
        rx = bx - ax;
        ry = by - ay;
        ox = (as_ + bs) - ((rx < 0) ? -rx : rx);
        oy = (ah + bh) - ((ry < 0) ? -ry : ry);
        if (ox > 0 && oy > 0) begin
          res.hit = 1'b1;
          // Smaller overlap wins; a tie goes to Y. Zero offset points negative.
          if (ox < oy) begin
            res.pen = PenW'(ox);
            res.nx = NormW'((rx > 0) ? one : -one);
          end else begin
            res.pen = PenW'(oy);
            res.ny = NormW'((ry > 0) ? one : -one);
          end
        end
      end
    endcase
    return res;
  endfunction

  function automatic bit chance(int pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  task automatic add_pair(input shape_pair_t p);
    pending_pairs = {pending_pairs, p};
  endtask

  // Driver: keeps valid and payload stable until the beat is taken.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_ready_o) begin
        if (pending_pairs.size() != 0 &&
            !(idle_phase == 0 && chance(35)) && !(idle_phase == 1 && chance(87))) begin
          drive_pair <= pending_pairs[0];
          expected_contacts = {expected_contacts, predict_contact(pending_pairs[0])};
          void'(pending_pairs.pop_front());
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each accepted result beat with the oldest prediction.
  always @(posedge clk_i) begin
    contact_t exp_c;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_contacts.size() == 0) begin
          $display("%0t: unexpected result beat hit=%0b nx=%0d ny=%0d pen=%0d",
                   $time, hit_o, normal_x_o, normal_y_o, penetration_o);
          errors++;
        end else begin
          exp_c = expected_contacts.pop_front();
          if (hit_o !== exp_c.hit) begin
            $display("%0t: hit expected %0b actual %0b", $time, exp_c.hit, hit_o);
            errors++;
          end
          if (normal_x_o !== exp_c.nx) begin
            $display("%0t: normal_x expected %0d actual %0d", $time, exp_c.nx, normal_x_o);
            errors++;
          end
          if (normal_y_o !== exp_c.ny) begin
            $display("%0t: normal_y expected %0d actual %0d", $time, exp_c.ny, normal_y_o);
            errors++;
          end
          if (penetration_o !== exp_c.pen) begin
            $display("%0t: penetration expected %0d actual %0d",
                     $time, exp_c.pen, penetration_o);
            errors++;
          end
        end
      end
      // The long hold-off is counted here so the pipe fills and backs up.
      if (hold_off && hold_cnt < 400) begin
        hold_cnt <= hold_cnt + 1;
        out_ready_i <= 1'b0;
      end else if (idle_phase == 0) begin
        out_ready_i <= !chance(87);
      end else if (idle_phase == 1) begin
        out_ready_i <= !chance(35);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (rst_ni) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  function automatic shape_pair_t pair_of(bit abox, longint ax, longint ay, longint as_,
                                          longint ah, bit bbox, longint bx, longint by,
                                          longint bs, longint bh);
    shape_pair_t p;
    p.a_box = abox; p.ax = PosW'(ax); p.ay = PosW'(ay);
    p.as_ = SizeW'(as_); p.ah = SizeW'(ah);
    p.b_box = bbox; p.bx = PosW'(bx); p.by = PosW'(by);
    p.bs = SizeW'(bs); p.bh = SizeW'(bh);
    return p;
  endfunction

  // Random pair, mostly close together so that contacts are frequent.
  function automatic shape_pair_t random_pair();
    shape_pair_t p;
    int spread;
    p.a_box = 1'($urandom_range(1, 0));
    p.b_box = 1'($urandom_range(1, 0));
    if (chance(15)) begin
      // Raw noise across the full field ranges.
      p.ax = $urandom; p.ay = $urandom; p.bx = $urandom; p.by = $urandom;
      p.as_ = SizeW'($urandom); p.ah = SizeW'($urandom);
      p.bs = SizeW'($urandom); p.bh = SizeW'($urandom);
    end else begin
      spread = $urandom_range(28, 4);
      p.ax = $urandom;
      p.ay = $urandom;
      p.as_ = SizeW'($urandom_range((1 << spread) - 1, 0));
      p.ah = SizeW'($urandom_range((1 << spread) - 1, 0));
      p.bs = SizeW'($urandom_range((1 << spread) - 1, 0));
      p.bh = SizeW'($urandom_range((1 << spread) - 1, 0));
      p.bx = p.ax + PosW'($signed($urandom_range((1 << (spread + 1)) - 1, 0)) - (1 << spread));
      p.by = p.ay + PosW'($signed($urandom_range((1 << (spread + 1)) - 1, 0)) - (1 << spread));
      if (chance(5)) p.by = p.ay;
      if (chance(5)) p.bx = p.ax;
    end
    return p;
  endfunction

  initial begin
    longint maxs;
    int waited;
    maxs = 64'h3FFF_FFFF;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed pairs: every shape combination, coincident centres, touching,
    // zero radii, box tie to Y, equal centres on the box axis, field extremes.
    add_pair(pair_of(0, 0, 0, 65536, 0, 0, 0, 0, 65536, 0));
    add_pair(pair_of(0, 0, 0, 65536, 0, 0, 131072, 0, 65536, 0));
    add_pair(pair_of(0, 0, 0, 65536, 0, 0, 70000, -50000, 65536, 0));
    add_pair(pair_of(0, 5, 5, 0, 0, 0, 5, 5, 0, 0));
    add_pair(pair_of(0, 5, 5, 0, 0, 1, 5, 5, 100, 100));
    add_pair(pair_of(0, 10, 10, 50, 0, 1, 0, 0, 100, 100));
    add_pair(pair_of(0, 150, 130, 60, 0, 1, 0, 0, 100, 100));
    add_pair(pair_of(1, 0, 0, 100, 100, 0, -150, 130, 60, 0));
    add_pair(pair_of(1, 0, 0, 100, 100, 0, 200, 0, 100, 0));
    add_pair(pair_of(1, 0, 0, 100, 100, 1, 50, 50, 100, 100));
    add_pair(pair_of(1, 0, 0, 100, 100, 1, 0, 0, 100, 100));
    add_pair(pair_of(1, 0, 0, 100, 300, 1, 0, 0, 100, 300));
    add_pair(pair_of(1, 0, 0, 100, 100, 1, -20, 190, 100, 100));
    add_pair(pair_of(1, 0, 0, 100, 100, 1, 200, 0, 100, 100));
    add_pair(pair_of(0, -2147483648, -2147483648, maxs, maxs,
                     0, 2147483647, 2147483647, maxs, maxs));
    add_pair(pair_of(1, -2147483648, 2147483647, maxs, maxs,
                     1, 2147483647, -2147483648, maxs, maxs));
    add_pair(pair_of(0, 2147483647, -2147483648, maxs, 0,
                     1, -2147483648, 2147483647, maxs, maxs));
    add_pair(pair_of(1, -1, -1, maxs, maxs, 0, 0, 0, maxs, maxs));
    add_pair(pair_of(0, 0, 0, maxs, 0, 0, 0, 0, maxs, 0));

    // Three idling phases; the long hold-off falls into the last one.
    for (int ph = 0; ph < 3; ph++) begin
      idle_phase = ph;
      for (int i = 0; i < RandomPairs / 3; i++) add_pair(random_pair());
      if (ph == 2) hold_off = 1'b1;
      while (pending_pairs.size() != 0) @(posedge clk_i);
    end

    waited = 0;
    while ((expected_contacts.size() != 0 || in_valid_i) && waited < 200000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (PipeLatency) @(posedge clk_i);
    if (errors == 0 && expected_contacts.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

@@ circle_box_contact_test.f @@
sv/cbct_pkg.sv
sv/cbct_setup.sv
sv/cbct_sqrt.sv
sv/cbct_div.sv
sv/circle_box_contact_test.sv
dv/tb_circle_box_contact_test.sv
